/* hw/rtl/msdpa_pkg.sv */
// ---------------------------------------------------------------------------
// msdpa_pkg - shared types and constants for the MSD accumulator
// Payload structs, command and register codes, datapath widths.
// ---------------------------------------------------------------------------
`default_nettype none

package msdpa_pkg;

  // Default sizing handed to the top level parameters
  localparam int DEF_MAX_FRAMES = 4096;
  localparam int DEF_MAX_LAGS   = 1024;
  localparam int DEF_MAX_AXES   = 8;
  localparam int DEF_POS_WIDTH  = 32;

  // Command codes
  localparam logic [1:0] CMD_LOAD_FRAME = 2'd0;
  localparam logic [1:0] CMD_LOAD_COEF  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE    = 2'd2;
  localparam logic [1:0] CMD_READ       = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_ORIGIN_STEP = 3'd1;
  localparam logic [2:0] REG_LAG_STEP    = 3'd2;
  localparam logic [2:0] REG_SKIP_FRAMES = 3'd3;
  localparam logic [2:0] REG_LAG_SPAN    = 3'd4;
  localparam logic [2:0] REG_AXIS_COUNT  = 3'd5;

  localparam int CFG_W  = 12;
  localparam int DIFF_W = 33;  // position difference, signed
  localparam int COEF_W = 16;  // Q1.14 coefficient
  localparam int TERM_W = 58;  // up to three squared terms
  localparam int SUM_W  = 63;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [2:0]         axis_index;
    logic [1:0]         axis_component;
    logic signed [15:0] coefficient;
    logic [9:0]         lag_index;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic             status;
    logic [SUM_W-1:0] sum_value;
  } result_t;

  // Operands for one squared-displacement term
  typedef struct packed {
    logic                     mode;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic signed [COEF_W-1:0] cx;
    logic signed [COEF_W-1:0] cy;
    logic signed [COEF_W-1:0] cz;
  } term_req_t;

endpackage

`default_nettype wire

/* hw/rtl/msdpa_term.sv */
// ---------------------------------------------------------------------------
// msdpa_term - squared displacement term on one shared multiplier
// Mode 0: sum of squared x, y, z differences. Mode 1: square of the
// projection onto one axis. Squares are split into 18-bit partial products.
// ---------------------------------------------------------------------------
`default_nettype none

module msdpa_term import msdpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  term_req_t         req,
  output logic              done,
  output logic [TERM_W-1:0] term
);

  localparam int PROD_W = 53;
  localparam int P_W    = 50;
  localparam int M_W    = 36;
  localparam int Y_W    = 56;

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_PMUL = 3'd1;
  localparam logic [2:0] T_PACC = 3'd2;
  localparam logic [2:0] T_PMAG = 3'd3;
  localparam logic [2:0] T_MAG  = 3'd4;
  localparam logic [2:0] T_SQ   = 3'd5;
  localparam logic [2:0] T_SACC = 3'd6;
  localparam logic [2:0] T_SUM  = 3'd7;

  logic [2:0]               st;
  logic [1:0]               cnt;
  logic [1:0]               sq_cnt;
  term_req_t                q;
  logic signed [PROD_W-1:0] prod;
  logic signed [P_W-1:0]    p;
  logic [M_W-1:0]           m;
  logic [35:0]              hi;
  logic [Y_W-1:0]           y;

  logic signed [DIFF_W-1:0] sel_d;
  logic signed [COEF_W-1:0] sel_c;
  logic [DIFF_W-1:0]        d_abs;
  logic [P_W-1:0]           p_abs;
  logic signed [33:0]       op_a;
  logic signed [18:0]       op_b;
  logic signed [PROD_W-1:0] mul;

  // Select the component in turn
  always_comb begin
    case (cnt)
      2'd0:    begin sel_d = q.dx; sel_c = q.cx; end
      2'd1:    begin sel_d = q.dy; sel_c = q.cy; end
      default: begin sel_d = q.dz; sel_c = q.cz; end
    endcase
  end

  assign d_abs = sel_d[DIFF_W-1] ? DIFF_W'(-sel_d) : DIFF_W'(sel_d);
  assign p_abs = p[P_W-1] ? P_W'(-p) : P_W'(p);

  // Shared multiplier operands: projection products or square partials
  always_comb begin
    if (st == T_PMUL) begin
      op_a = 34'(sel_d);
      op_b = 19'(sel_c);
    end else begin
      case (sq_cnt)
        2'd0: begin
          op_a = $signed({16'b0, m[35:18]});
          op_b = $signed({1'b0, m[35:18]});
        end
        2'd1: begin
          op_a = $signed({16'b0, m[35:18]});
          op_b = $signed({1'b0, m[17:0]});
        end
        default: begin
          op_a = $signed({16'b0, m[17:0]});
          op_b = $signed({1'b0, m[17:0]});
        end
      endcase
    end
  end

  assign mul = PROD_W'(op_a * op_b);

  // Sequence the products for one term
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= T_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        T_IDLE: begin
          if (start) begin
            q    <= req;
            term <= '0;
            cnt  <= 2'd0;
            p    <= '0;
            st   <= req.mode ? T_PMUL : T_MAG;
          end
        end
        T_PMUL: begin
          prod <= mul;
          st   <= T_PACC;
        end
        T_PACC: begin
          p <= p + P_W'(prod);
          if (cnt == 2'd2) begin
            st <= T_PMAG;
          end else begin
            cnt <= cnt + 2'd1;
            st  <= T_PMUL;
          end
        end
        T_PMAG: begin
          m      <= M_W'(p_abs >> 14);
          sq_cnt <= 2'd0;
          st     <= T_SQ;
        end
        T_MAG: begin
          m      <= M_W'(d_abs);
          sq_cnt <= 2'd0;
          st     <= T_SQ;
        end
        T_SQ: begin
          prod <= mul;
          st   <= T_SACC;
        end
        T_SACC: begin
          case (sq_cnt)
            2'd0:    hi <= prod[35:0];
            2'd1:    y  <= Y_W'(prod[35:0]) << 19;
            default: y  <= y + Y_W'(prod[35:0]);
          endcase
          if (sq_cnt == 2'd2) begin
            st <= T_SUM;
          end else begin
            sq_cnt <= sq_cnt + 2'd1;
            st     <= T_SQ;
          end
        end
        T_SUM: begin
          term <= term + TERM_W'({hi, 20'b0}) + TERM_W'(y >> 16);
          if (q.mode || cnt == 2'd2) begin
            done <= 1'b1;
            st   <= T_IDLE;
          end else begin
            cnt <= cnt + 2'd1;
            st  <= T_MAG;
          end
        end
        default: st <= T_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/msd_projected_accumulator_core.sv */
// ---------------------------------------------------------------------------
// msd_projected_accumulator_core - mean squared displacement accumulator
// Loads frames and axis coefficients, sums squared displacements per lag
// and axis into a saturating sum memory, and returns single sums on read.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  item     | in        | item_valid / item_ready   | item_t
//  result   | out       | result_valid / result_ready | result_t
//  cfg      | in        | cfg_we                    | cfg_index, cfg_data
//
//  Loads leave item_ready high. A read holds item_ready low through S_RDW,
//  S_RDD and S_OUT. Sums read as zero until the first compute. A compute
//  first clears all MAX_AXES*MAX_LAGS entries of the sum memory, scans to
//  the last origin and lag below the span, then for each origin and lag
//  runs one term (mode 0) or one term per axis (mode 1) on the shared
//  multiplier. item_ready is low meanwhile.
//  A result waits in the output register while later loads are taken.
// ---------------------------------------------------------------------------
`default_nettype none

module msd_projected_accumulator_core import msdpa_pkg::*; #(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int MAX_LAGS   = DEF_MAX_LAGS,
  parameter int MAX_AXES   = DEF_MAX_AXES,
  parameter int POS_WIDTH  = DEF_POS_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_ready,
  output result_t          result,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int FAW   = $clog2(MAX_FRAMES);
  localparam int FLW   = $clog2(MAX_FRAMES + 1);
  localparam int SLOTS = MAX_AXES * MAX_LAGS;
  localparam int SAW   = $clog2(SLOTS);
  localparam int SCW   = $clog2(SLOTS + 1);
  localparam int KW    = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int IW    = 14;
  localparam int CW    = (FLW > IW + 1) ? FLW : IW + 1;
  localparam int SLW   = ($clog2(MAX_LAGS + 1) > 13) ? $clog2(MAX_LAGS + 1) : 13;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDW   = 4'd1;
  localparam logic [3:0] S_RDD   = 4'd2;
  localparam logic [3:0] S_CLR   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_ORG   = 4'd6;
  localparam logic [3:0] S_ORGD  = 4'd7;
  localparam logic [3:0] S_LAG   = 4'd8;
  localparam logic [3:0] S_LAGD  = 4'd9;
  localparam logic [3:0] S_TGO   = 4'd10;
  localparam logic [3:0] S_TWAIT = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  // Configuration registers
  logic        mode;
  logic [10:0] origin_step;
  logic [11:0] lag_step;
  logic [10:0] skip_frames;
  logic [11:0] lag_span;
  logic [3:0]  axis_count;

  // Control and loop state
  logic [3:0]     st;
  logic [FLW-1:0] frames_loaded;
  logic [SCW-1:0] clr_cnt;
  logic [IW-1:0]  first;
  logic [IW-1:0]  li;
  logic [IW-1:0]  lj;
  logic [IW-1:0]  i;
  logic [IW-1:0]  j;
  logic [SLW-1:0] slot;
  logic [KW-1:0]  k;
  logic [2:0]     rd_ax;
  logic [9:0]     rd_lag;
  logic           rd_bad;
  logic           sums_live;
  result_t        pend;
  logic           res_valid;
  result_t        res;

  // Frame and sum memories, coefficient flops
  logic [POS_WIDTH-1:0] mem_x [MAX_FRAMES];
  logic [POS_WIDTH-1:0] mem_y [MAX_FRAMES];
  logic [POS_WIDTH-1:0] mem_z [MAX_FRAMES];
  logic [POS_WIDTH-1:0] fr_x, fr_y, fr_z;
  logic [POS_WIDTH-1:0] xi, yi, zi;
  logic [SUM_W-1:0]     sum_mem [SLOTS];
  logic [SUM_W-1:0]     sum_rd;
  logic signed [COEF_W-1:0] coef_x [MAX_AXES];
  logic signed [COEF_W-1:0] coef_y [MAX_AXES];
  logic signed [COEF_W-1:0] coef_z [MAX_AXES];
  logic signed [DIFF_W-1:0] dx, dy, dz;

  logic              acc;
  logic [IW-1:0]     os;
  logic [IW-1:0]     ls;
  logic [3:0]        na;
  logic [CW-1:0]     fr_full;
  logic [FAW-1:0]    fr_addr;
  logic [31:0]       acc_addr_full;
  logic [31:0]       rd_addr_full;
  logic [SAW-1:0]    sum_raddr;
  logic              sum_we;
  logic [SAW-1:0]    sum_waddr;
  logic [SUM_W-1:0]  sum_wdata;
  logic [SUM_W:0]    sum_add;
  logic              term_start;
  logic              term_done;
  logic [TERM_W-1:0] term;
  term_req_t         term_req;
  logic [31:0]       ax_full;
  logic [KW-1:0]     ax_sel;

  assign acc        = item_valid && item_ready;
  assign item_ready = (st == S_IDLE);
  assign result_valid = res_valid;
  assign result       = res;

  // Zero strides act as one; clamp the axis count
  assign os = (origin_step == 11'd0) ? IW'(1) : IW'(origin_step);
  assign ls = (lag_step == 12'd0) ? IW'(1) : IW'(lag_step);
  assign na = (32'(axis_count) > MAX_AXES) ? 4'(MAX_AXES) : axis_count;

  assign ax_full = 32'(item.axis_index);
  assign ax_sel  = ax_full[KW-1:0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b0;
      origin_step <= 11'd1;
      lag_step    <= 12'd1;
      skip_frames <= 11'd0;
      lag_span    <= 12'd1024;
      axis_count  <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:        mode        <= cfg_data[0];
        REG_ORIGIN_STEP: origin_step <= cfg_data[10:0];
        REG_LAG_STEP:    lag_step    <= cfg_data[11:0];
        REG_SKIP_FRAMES: skip_frames <= cfg_data[10:0];
        REG_LAG_SPAN:    lag_span    <= cfg_data[11:0];
        REG_AXIS_COUNT:  axis_count  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Coefficient store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < MAX_AXES; a++) begin
        coef_x[a] <= '0;
        coef_y[a] <= '0;
        coef_z[a] <= '0;
      end
    end else if (acc && item.command == CMD_LOAD_COEF && ax_full < MAX_AXES) begin
      case (item.axis_component)
        2'd0:    coef_x[ax_sel] <= item.coefficient;
        2'd1:    coef_y[ax_sel] <= item.coefficient;
        2'd2:    coef_z[ax_sel] <= item.coefficient;
        default: ;
      endcase
    end
  end

  // Frame memories: write at the fill count, registered read
  assign fr_full = CW'(i) + ((st == S_ORG) ? CW'(0) : CW'(j));
  assign fr_addr = fr_full[FAW-1:0];

  always_ff @(posedge clk) begin
    if (acc && item.command == CMD_LOAD_FRAME && frames_loaded < MAX_FRAMES) begin
      mem_x[frames_loaded[FAW-1:0]] <= item.pos_x[POS_WIDTH-1:0];
      mem_y[frames_loaded[FAW-1:0]] <= item.pos_y[POS_WIDTH-1:0];
      mem_z[frames_loaded[FAW-1:0]] <= item.pos_z[POS_WIDTH-1:0];
    end
    fr_x <= mem_x[fr_addr];
    fr_y <= mem_y[fr_addr];
    fr_z <= mem_z[fr_addr];
  end

  // Sum memory addressing, saturating accumulate
  assign acc_addr_full = 32'(k) * MAX_LAGS + 32'(slot);
  assign rd_addr_full  = 32'(rd_ax) * MAX_LAGS + 32'(rd_lag);
  assign sum_raddr = (st == S_RDW) ? rd_addr_full[SAW-1:0] : acc_addr_full[SAW-1:0];
  assign sum_add   = {1'b0, sum_rd} + (SUM_W + 1)'(term);

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = acc_addr_full[SAW-1:0];
    sum_wdata = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    if (st == S_CLR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_cnt[SAW-1:0];
      sum_wdata = '0;
    end else if (st == S_TWAIT && term_done) begin
      sum_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rd <= sum_mem[sum_raddr];
  end

  // Term unit
  assign term_start     = (st == S_TGO);
  assign term_req.mode  = mode;
  assign term_req.dx    = dx;
  assign term_req.dy    = dy;
  assign term_req.dz    = dz;
  assign term_req.cx    = coef_x[k];
  assign term_req.cy    = coef_y[k];
  assign term_req.cz    = coef_z[k];

  msdpa_term u_term (
    .clk   (clk),
    .rst   (rst),
    .start (term_start),
    .req   (term_req),
    .done  (term_done),
    .term  (term)
  );

  // Sequencer over commands, origins, lags and axes
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      frames_loaded <= '0;
      res_valid     <= 1'b0;
      sums_live     <= 1'b0;
    end else begin
      // Drop the output register once taken, unless refilled below
      if (res_valid && result_ready && st != S_OUT) begin
        res_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (acc) begin
            case (item.command)
              CMD_LOAD_FRAME: begin
                if (frames_loaded < MAX_FRAMES) begin
                  frames_loaded <= frames_loaded + FLW'(1);
                end
              end
              CMD_COMPUTE: begin
                clr_cnt   <= '0;
                first     <= IW'(skip_frames) + os;
                sums_live <= 1'b1;
                st        <= S_CLR;
              end
              CMD_READ: begin
                rd_ax  <= item.axis_index;
                rd_lag <= item.lag_index;
                rd_bad <= !sums_live ||
                          !(ax_full < MAX_AXES && 32'(item.lag_index) < MAX_LAGS);
                st     <= S_RDW;
              end
              default: ;
            endcase
          end
        end
        S_RDW: st <= S_RDD;
        S_RDD: begin
          pend.kind      <= 1'b1;
          pend.status    <= 1'b0;
          pend.sum_value <= rd_bad ? '0 : sum_rd;
          st             <= S_OUT;
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + SCW'(1);
          if (clr_cnt == SCW'(SLOTS - 1)) begin
            pend <= '0;
            if (first >= IW'(lag_span)) begin
              st <= S_OUT;
            end else begin
              li <= first;
              lj <= '0;
              st <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Step to the last origin and the last lag below the span
          if (li + os < IW'(lag_span)) begin
            li <= li + os;
          end
          if (lj + ls < IW'(lag_span)) begin
            lj <= lj + ls;
          end
          if (!(li + os < IW'(lag_span)) && !(lj + ls < IW'(lag_span))) begin
            st <= S_CHK;
          end
        end
        S_CHK: begin
          if (CW'(li) + CW'(lj) >= CW'(frames_loaded)) begin
            pend.status <= 1'b1;
            st          <= S_OUT;
          end else begin
            i  <= first;
            st <= S_ORG;
          end
        end
        S_ORG: st <= S_ORGD;
        S_ORGD: begin
          xi   <= fr_x;
          yi   <= fr_y;
          zi   <= fr_z;
          j    <= '0;
          slot <= '0;
          st   <= S_LAG;
        end
        S_LAG: begin
          if (j >= IW'(lag_span) || 32'(slot) >= MAX_LAGS) begin
            if (i + os >= IW'(lag_span)) begin
              st <= S_OUT;
            end else begin
              i  <= i + os;
              st <= S_ORG;
            end
          end else begin
            st <= S_LAGD;
          end
        end
        S_LAGD: begin
          dx <= DIFF_W'($signed(fr_x)) - DIFF_W'($signed(xi));
          dy <= DIFF_W'($signed(fr_y)) - DIFF_W'($signed(yi));
          dz <= DIFF_W'($signed(fr_z)) - DIFF_W'($signed(zi));
          k  <= '0;
          if (mode && na == 4'd0) begin
            j    <= j + ls;
            slot <= slot + SLW'(1);
            st   <= S_LAG;
          end else begin
            st <= S_TGO;
          end
        end
        S_TGO: st <= S_TWAIT;
        S_TWAIT: begin
          if (term_done) begin
            if (mode && (32'(k) + 32'd1 < 32'(na))) begin
              k  <= k + KW'(1);
              st <= S_TGO;
            end else begin
              j    <= j + ls;
              slot <= slot + SLW'(1);
              st   <= S_LAG;
            end
          end
        end
        S_OUT: begin
          // Hand the result over once the output register is free
          if (!res_valid || result_ready) begin
            res_valid <= 1'b1;
            res       <= pend;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* bench/msd_projected_accumulator_core_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// msd_projected_accumulator_core_tb - self-checking bench for the MSD core
// Drives frame, coefficient, compute and read transfers through the item
// channel, and predicts every result with an in-bench accumulator. The
// bench runs a directed table, then random phases under several register
// settings, then a longer span over the loaded frames.
// ---------------------------------------------------------------------------
`default_nettype none

module msd_projected_accumulator_core_tb;
  import msdpa_pkg::*;

  localparam int N_FRAMES   = 4096;
  localparam int N_LAGS     = 1024;
  localparam int N_AXES     = 8;
  localparam int STALL_MAX  = 500000;
  localparam longint unsigned SUM_SAT = 64'h7FFF_FFFF_FFFF_FFFF;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  item_t            item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  result_t          result;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = REG_MODE;
  logic [CFG_W-1:0] cfg_data = '0;

  msd_projected_accumulator_core uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Accumulator state mirrored in the bench
  logic signed [31:0] pos_x_mem [N_FRAMES];
  logic signed [31:0] pos_y_mem [N_FRAMES];
  logic signed [31:0] pos_z_mem [N_FRAMES];
  logic signed [15:0] coef_mem [N_AXES*3];
  longint unsigned    lag_sums [N_AXES*N_LAGS];
  int unsigned        frame_count;
  int unsigned        r_mode, r_ostep, r_lstep, r_skip, r_span, r_axes;

  result_t pending_results[$];
  int      mismatches = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  // Directed stimulus table
  item_t   dir_item [23];
  bit      dir_typed [23];
  result_t dir_want [23];

  initial begin
    forever #5 clk = ~clk;
  end

  // floor(m*m / 2^16)
  function automatic longint unsigned sq_q16(longint unsigned m);
    logic [127:0] w;
    w = {64'd0, m} * {64'd0, m};
    return w[79:16];
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  task automatic add_sat(int unsigned slot, longint unsigned v);
    longint unsigned s;
    s = lag_sums[slot] + v;
    lag_sums[slot] = (s > SUM_SAT) ? SUM_SAT : s;
  endtask

  // Clear the sums, then accumulate squared displacements per lag and axis
  task automatic accumulate_msd(output bit too_few);
    int unsigned os, ls, na, first, last_i, last_j, i, j, k, slot, f;
    longint dx, dy, dz, p;
    os = (r_ostep == 0) ? 1 : r_ostep;
    ls = (r_lstep == 0) ? 1 : r_lstep;
    na = (r_axes > N_AXES) ? N_AXES : r_axes;
    first = r_skip + os;
    too_few = 1'b0;
    foreach (lag_sums[n]) lag_sums[n] = 0;
    if (first >= r_span) return;
    last_i = first + ((r_span - 1 - first) / os) * os;
    last_j = ((r_span - 1) / ls) * ls;
    if (last_i + last_j >= frame_count) begin
      too_few = 1'b1;
      return;
    end
    for (i = first; i < r_span; i += os) begin
      for (j = 0; j < r_span; j += ls) begin
        slot = j / ls;
        if (slot >= N_LAGS) break;
        f = i + j;
        dx = longint'(pos_x_mem[f]) - longint'(pos_x_mem[i]);
        dy = longint'(pos_y_mem[f]) - longint'(pos_y_mem[i]);
        dz = longint'(pos_z_mem[f]) - longint'(pos_z_mem[i]);
        if (r_mode == 0) begin
          add_sat(slot, sq_q16(abs64(dx)) + sq_q16(abs64(dy)) + sq_q16(abs64(dz)));
        end else begin
          for (k = 0; k < na; k++) begin
            p = dx * longint'(coef_mem[3*k]) + dy * longint'(coef_mem[3*k+1])
              + dz * longint'(coef_mem[3*k+2]);
            add_sat(k * N_LAGS + slot, sq_q16(abs64(p) >> 14));
          end
        end
      end
    end
  endtask

  // Apply one accepted item and queue the result it causes
  task automatic track_item(item_t it, bit typed, result_t want);
    result_t r;
    bit      st;
    r = '0;
    case (it.command)
      CMD_LOAD_FRAME: begin
        if (frame_count < N_FRAMES) begin
          pos_x_mem[frame_count] = it.pos_x;
          pos_y_mem[frame_count] = it.pos_y;
          pos_z_mem[frame_count] = it.pos_z;
          frame_count++;
        end
        return;
      end
      CMD_LOAD_COEF: begin
        if (it.axis_component != 2'd3)
          coef_mem[3*it.axis_index + it.axis_component] = it.coefficient;
        return;
      end
      CMD_COMPUTE: begin
        accumulate_msd(st);
        r.status = st;
      end
      default: begin
        r.kind = 1'b1;
        r.sum_value = lag_sums[it.axis_index * N_LAGS + it.lag_index][SUM_W-1:0];
      end
    endcase
    pending_results.push_back(typed ? want : r);
  endtask

  // Offer one item, idling first at random, and hold it until the transfer
  task automatic send_item(item_t it, bit typed = 1'b0, result_t want = '0);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    track_item(it, typed, want);
  endtask

  // Wait for the block to drain before touching the registers
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned m, int unsigned os, int unsigned ls,
                          int unsigned sk, int unsigned sp, int unsigned ac);
    logic [CFG_W-1:0] vals [6];
    logic [2:0]       idx [6];
    vals = '{CFG_W'(m), CFG_W'(os), CFG_W'(ls), CFG_W'(sk), CFG_W'(sp), CFG_W'(ac)};
    idx  = '{REG_MODE, REG_ORIGIN_STEP, REG_LAG_STEP, REG_SKIP_FRAMES,
             REG_LAG_SPAN, REG_AXIS_COUNT};
    for (int n = 0; n < 6; n++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[n];
      cfg_data <= vals[n];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    r_mode  = m & 1;
    r_ostep = os & 12'h7FF;
    r_lstep = ls & 12'hFFF;
    r_skip  = sk & 12'h7FF;
    r_span  = sp & 12'hFFF;
    r_axes  = ac & 4'hF;
  endtask

  function automatic item_t noise_item();
    item_t it;
    it.command = CMD_READ;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    it.axis_index = 3'($urandom_range(7));
    it.axis_component = 2'($urandom_range(3));
    it.coefficient = 16'($urandom);
    it.lag_index = 10'($urandom_range(1023));
    return it;
  endfunction

  function automatic item_t frame_item(int x, int y, int z);
    item_t it;
    it = noise_item();
    it.command = CMD_LOAD_FRAME;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    return it;
  endfunction

  function automatic item_t coef_item(int ax, int comp, int c);
    item_t it;
    it = noise_item();
    it.command = CMD_LOAD_COEF;
    it.axis_index = 3'(ax);
    it.axis_component = 2'(comp);
    it.coefficient = 16'(c);
    return it;
  endfunction

  function automatic item_t read_item(int ax, int lag);
    item_t it;
    it = noise_item();
    it.axis_index = 3'(ax);
    it.lag_index = 10'(lag);
    return it;
  endfunction

  function automatic item_t compute_item();
    item_t it;
    it = noise_item();
    it.command = CMD_COMPUTE;
    return it;
  endfunction

  // Random item: mostly loads and reads with small lags, few computes
  function automatic item_t random_item(int unsigned frame_cap);
    item_t it;
    int unsigned pick;
    it = noise_item();
    pick = $urandom_range(99);
    if (pick < 30 && frame_count < frame_cap) begin
      it.command = CMD_LOAD_FRAME;
      if ($urandom_range(1)) begin
        it.pos_x = int'($urandom_range(1 << 20)) - (1 << 19);
        it.pos_y = int'($urandom_range(1 << 20)) - (1 << 19);
        it.pos_z = int'($urandom_range(1 << 20)) - (1 << 19);
      end
    end else if (pick < 55) begin
      it.command = CMD_LOAD_COEF;
    end else if (pick < 59) begin
      it.command = CMD_COMPUTE;
    end else if ($urandom_range(9) < 7) begin
      it.lag_index = 10'($urandom_range(20));
    end
    return it;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d status=%0d sum=%0h",
                 $time, result.kind, result.status, result.sum_value);
        mismatches++;
      end else begin
        result_t want;
        want = pending_results.pop_front();
        if (result.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, result.kind);
          mismatches++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   result.status);
          mismatches++;
        end
        if (result.sum_value !== want.sum_value) begin
          $display("%0t: sum_value expected %0h actual %0h", $time, want.sum_value,
                   result.sum_value);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    frame_count = 0;
    foreach (coef_mem[n]) coef_mem[n] = 0;
    foreach (lag_sums[n]) lag_sums[n] = 0;
    r_mode = 0; r_ostep = 1; r_lstep = 1; r_skip = 0; r_span = 1024; r_axes = 3;

    // Directed table: reset read, empty compute, extremes, all operations
    dir_item[0]  = read_item(0, 0);
    dir_item[1]  = compute_item();
    dir_item[2]  = coef_item(0, 0, -32768);
    dir_item[3]  = coef_item(0, 1, 32767);
    dir_item[4]  = coef_item(0, 2, 0);
    dir_item[5]  = coef_item(7, 2, 32767);
    dir_item[6]  = coef_item(3, 3, 1234);
    dir_item[7]  = coef_item(1, 0, 16384);
    dir_item[8]  = frame_item(32'h7FFFFFFF, 32'h80000000, 0);
    dir_item[9]  = frame_item(32'h80000000, 32'h7FFFFFFF, -1);
    dir_item[10] = frame_item(0, 0, 0);
    dir_item[11] = frame_item(-1, 1, 65536);
    dir_item[12] = frame_item(32'h12345678, -32'sd5000000, 32'h7FFFFFFF);
    dir_item[13] = frame_item(70000, -70000, 123456);
    dir_item[14] = frame_item(-200000, 300000, -65536);
    dir_item[15] = compute_item();
    dir_item[16] = read_item(0, 0);
    dir_item[17] = read_item(0, 1);
    dir_item[18] = read_item(0, 3);
    dir_item[19] = read_item(1, 2);
    dir_item[20] = read_item(7, 3);
    dir_item[21] = read_item(2, 1);
    dir_item[22] = read_item(7, 1023);
    foreach (dir_typed[n]) begin
      dir_typed[n] = 1'b0;
      dir_want[n] = '0;
    end
    dir_typed[0] = 1'b1;
    dir_want[0] = '{kind: 1'b1, status: 1'b0, sum_value: '0};
    dir_typed[1] = 1'b1;
    dir_want[1] = '{kind: 1'b0, status: 1'b1, sum_value: '0};
    dir_typed[22] = 1'b1;
    dir_want[22] = '{kind: 1'b1, status: 1'b0, sum_value: '0};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    settle();

    // Zero strides act as one; axis count above the store is clipped
    set_regs(1, 0, 0, 0, 4, 15);
    for (int n = 0; n < 23; n++) send_item(dir_item[n], dir_typed[n], dir_want[n]);

    // Random phases under changing register settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      send_idle = (ph < 2) ? 28 : (ph < 4) ? 46 : 0;
      recv_idle = (ph < 2) ? 46 : (ph < 4) ? 28 : 0;
      if (ph == 1)
        set_regs(0, 2047, 2048, 2047, 2048, 0);
      else if (ph == 3)
        set_regs(1, 1, 1, 0, 1, 8);
      else
        set_regs($urandom_range(1), $urandom_range(3), $urandom_range(4),
                 $urandom_range(4), $urandom_range(2, 20), $urandom_range(9));
      if (ph == 4) begin
        hold_req = 1'b1;
        for (int n = 0; n < 24; n++) send_item(read_item($urandom_range(7), $urandom_range(20)));
      end
      for (int n = 0; n < 125; n++) send_item(random_item(1000));
    end

    // Longer span over the loaded frames, plain squares
    settle();
    set_regs(0, 3, 2, 1, 40, 1);
    send_item(compute_item());
    for (int n = 0; n < 6; n++) send_item(read_item(0, $urandom_range(20)));

    // Drain
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/msdpa_pkg.sv
hw/rtl/msdpa_term.sv
hw/rtl/msd_projected_accumulator_core.sv
bench/msd_projected_accumulator_core_tb.sv
